// ===== rtl/scba_pkg.sv =====
// package for the size-class block allocator: codes, field types, class geometry
// used by scba_ctrl, scba_dp and size_class_block_allocator
package scba_pkg;

  localparam int unsigned NumClasses = 4;
  localparam int unsigned SmallBlocks = 16;
  localparam int unsigned MediumBlocks = 16;
  localparam int unsigned LargeBlocks = 16;
  localparam int unsigned XlBlocks = 16;
  localparam int unsigned TotalBlocks = SmallBlocks + MediumBlocks + LargeBlocks + XlBlocks;
  localparam int unsigned BlkW = $clog2(TotalBlocks);
  localparam int unsigned LinkW = 9;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_REINIT = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_HYBRID  = 2'd0,
    MODE_STATIC  = 2'd1,
    MODE_DYNAMIC = 2'd2,
    MODE_OTHER   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_ENABLED = 3'd1,
    ST_ZERO_SIZE   = 3'd2,
    ST_TOO_LARGE   = 3'd3,
    ST_CLASS_EMPTY = 3'd4,
    ST_DYNAMIC     = 3'd5,
    ST_BAD_HANDLE  = 3'd6,
    ST_DOUBLE_FREE = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    REG_POOL_ENABLE  = 3'd0,
    REG_SMALL_LIMIT  = 3'd1,
    REG_MEDIUM_LIMIT = 3'd2,
    REG_LARGE_LIMIT  = 3'd3,
    REG_XL_LIMIT     = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_CLEAR,
    FSM_OUT
  } fsm_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] req_size;
    logic [1:0]  alloc_mode;
    logic [1:0]  target_class;
    logic [3:0]  target_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  granted_class;
    logic [3:0]  granted_index;
    logic [15:0] seq_number;
    logic [4:0]  used_blocks;
    logic [4:0]  peak_blocks;
    logic [31:0] alloc_count;
    logic [31:0] free_count;
    logic [31:0] fail_count;
    logic [6:0]  usage_percent;
  } rsp_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;    // latch request, read link and busy entries
    logic exec;       // apply the request
    logic clr_start;  // start the list rebuild sweep
    logic clr_step;   // write one link entry
  } cmd_t;

  typedef struct packed {
    logic clr_done;   // last entry written
    logic is_reinit;  // captured request is a reinit with the pool enabled
    logic init_done;  // start-up sweep finished, tables usable
  } sts_t;

  function automatic logic [8:0] class_count(input logic [1:0] c);
    logic [8:0] r;
    unique case (c)
      2'd0: r = 9'(SmallBlocks);
      2'd1: r = 9'(MediumBlocks);
      2'd2: r = 9'(LargeBlocks);
      default: r = 9'(XlBlocks);
    endcase
    return r;
  endfunction

  function automatic logic [BlkW-1:0] class_base(input logic [1:0] c);
    logic [BlkW-1:0] r;
    unique case (c)
      2'd0: r = '0;
      2'd1: r = BlkW'(SmallBlocks);
      2'd2: r = BlkW'(SmallBlocks + MediumBlocks);
      default: r = BlkW'(SmallBlocks + MediumBlocks + LargeBlocks);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/scba_ctrl.sv =====
// controller state machine for the size-class block allocator
// depends on scba_pkg; drives commands into scba_dp
module scba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  input  scba_pkg::sts_t  sts_i,
  output scba_pkg::cmd_t  cmd_o
);

  scba_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scba_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    m_tvalid_o = 1'b0;
    unique case (state_q)
      scba_pkg::FSM_IDLE: begin
        // held off until the start-up sweep has filled the tables
        s_tready_o = sts_i.init_done;
        if (s_tvalid_i && sts_i.init_done) begin
          cmd_o.capture = 1'b1;
          state_d = scba_pkg::FSM_EXEC;
        end
      end
      scba_pkg::FSM_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_reinit) begin
          cmd_o.clr_start = 1'b1;
          state_d = scba_pkg::FSM_CLEAR;
        end else begin
          state_d = scba_pkg::FSM_OUT;
        end
      end
      scba_pkg::FSM_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = scba_pkg::FSM_OUT;
        end
      end
      scba_pkg::FSM_OUT: begin
        m_tvalid_o = 1'b1;
        s_tready_o = m_tready_i;
        if (m_tready_i) begin
          if (s_tvalid_i) begin
            cmd_o.capture = 1'b1;
            state_d = scba_pkg::FSM_EXEC;
          end else begin
            state_d = scba_pkg::FSM_IDLE;
          end
        end
      end
      default: state_d = scba_pkg::FSM_IDLE;
    endcase
  end

  a_out_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scba_pkg::FSM_EXEC && !sts_i.is_reinit) |=> m_tvalid_o)
    else $error("result not presented after execute");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scba_pkg::FSM_CLEAR) |-> !s_tready_o)
    else $error("input accepted during rebuild");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> m_tvalid_o)
    else $error("result dropped while stalled");

endmodule

// ===== rtl/scba_dp.sv =====
// datapath: link and busy tables, per-class tallies and result register
// depends on scba_pkg; sequenced by scba_ctrl
module scba_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scba_pkg::cmd_t         cmd_i,
  output scba_pkg::sts_t         sts_o,
  input  scba_pkg::req_t         req_i,
  input  logic                   pool_enable_i,
  input  logic [3:0][15:0]       limits_i,
  output scba_pkg::rsp_t         rsp_o
);

  localparam int unsigned N = scba_pkg::TotalBlocks;
  localparam int unsigned BW = scba_pkg::BlkW;

  logic [scba_pkg::LinkW-1:0] link_mem [N];
  logic               busy_mem [N];
  logic [3:0][8:0]    head_q;
  logic [3:0][4:0]    used_q, peak_q;
  logic [3:0][31:0]   alloc_q, rel_q, fail_q;
  logic [15:0]        seq_q;
  scba_pkg::req_t     req_q;
  logic               en_q;
  logic [1:0]         cls_q;
  logic               hit_q;
  logic [scba_pkg::LinkW-1:0] link_rd_q;
  logic               busy_rd_q;
  logic [BW:0]        clr_q;
  scba_pkg::rsp_t     rsp_q, rsp_d;

  // size class search at capture
  logic [1:0] sel_cls;
  logic       sel_hit;
  always_comb begin
    sel_cls = 2'd0;
    sel_hit = 1'b0;
    for (int c = 3; c >= 0; c--) begin
      if (req_i.req_size <= limits_i[c]) begin
        sel_cls = 2'(c);
        sel_hit = 1'b1;
      end
    end
  end

  logic [1:0]  cap_cls;
  logic [BW-1:0] cap_blk;
  logic [8:0]  cap_head;
  always_comb begin
    cap_cls  = (req_i.req_type == scba_pkg::REQ_ALLOC) ? sel_cls : req_i.target_class;
    cap_head = head_q[cap_cls];
    if (req_i.req_type == scba_pkg::REQ_ALLOC) begin
      cap_blk = scba_pkg::class_base(cap_cls) + BW'(cap_head);
    end else begin
      cap_blk = scba_pkg::class_base(cap_cls) + BW'(req_i.target_index);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q     <= req_i;
      cls_q     <= cap_cls;
      link_rd_q <= link_mem[cap_blk];
      busy_rd_q <= busy_mem[cap_blk];
      en_q      <= pool_enable_i;
      hit_q     <= sel_hit;
    end
  end

  // execution decode
  logic [8:0]    cnt;
  logic [BW-1:0] blk;
  logic          idx_ok, a_ok, f_ok, charge_fail;
  logic [2:0]    st;
  logic          no_class;
  always_comb begin
    cnt = scba_pkg::class_count(cls_q);
    idx_ok = {5'd0, req_q.target_index} < cnt;
    blk = (req_q.req_type == scba_pkg::REQ_ALLOC) ?
          scba_pkg::class_base(cls_q) + BW'(head_q[cls_q]) :
          scba_pkg::class_base(cls_q) + BW'(req_q.target_index);
    a_ok = 1'b0; f_ok = 1'b0; charge_fail = 1'b0; no_class = 1'b0;
    st = scba_pkg::ST_OK;
    if (!en_q) begin
      st = scba_pkg::ST_NOT_ENABLED; no_class = 1'b1;
    end else begin
      unique case (req_q.req_type)
        scba_pkg::REQ_ALLOC: begin
          if (req_q.req_size == 16'd0) begin
            st = scba_pkg::ST_ZERO_SIZE; no_class = 1'b1;
          end else if (!hit_q) begin
            st = scba_pkg::ST_TOO_LARGE; no_class = 1'b1;
          end else if (req_q.alloc_mode == scba_pkg::MODE_DYNAMIC) begin
            st = scba_pkg::ST_DYNAMIC; charge_fail = 1'b1;
          end else if (head_q[cls_q] >= cnt) begin
            st = scba_pkg::ST_CLASS_EMPTY; charge_fail = 1'b1;
          end else begin
            a_ok = 1'b1;
          end
        end
        scba_pkg::REQ_FREE: begin
          if (!idx_ok) begin
            st = scba_pkg::ST_BAD_HANDLE;
          end else if (!busy_rd_q) begin
            st = scba_pkg::ST_DOUBLE_FREE;
          end else begin
            f_ok = 1'b1;
          end
        end
        default: st = scba_pkg::ST_OK;
      endcase
    end
  end

  logic reinit;
  assign reinit = en_q && (req_q.req_type == scba_pkg::REQ_REINIT);
  assign sts_o.is_reinit = reinit;
  assign sts_o.clr_done  = (clr_q == (BW+1)'(N - 1));

  // next tallies for the addressed class
  logic [4:0] used_n, peak_n;
  logic [31:0] alloc_n, rel_n, fail_n;
  always_comb begin
    used_n  = used_q[cls_q];
    peak_n  = peak_q[cls_q];
    alloc_n = alloc_q[cls_q];
    rel_n   = rel_q[cls_q];
    fail_n  = fail_q[cls_q];
    if (a_ok) begin
      used_n  = used_n + 5'd1;
      alloc_n = alloc_n + 32'd1;
      if (used_n > peak_n) peak_n = used_n;
    end
    if (f_ok) begin
      if (used_n != 5'd0) used_n = used_n - 5'd1;
      rel_n = rel_n + 32'd1;
    end
    if (charge_fail) fail_n = fail_n + 32'd1;
    if (reinit) begin
      used_n = '0; peak_n = '0; alloc_n = '0; rel_n = '0; fail_n = '0;
    end
  end

  // usage percent: used*100/count, count is a class constant
  logic [11:0] pct_full;
  logic [6:0]  pct;
  always_comb begin
    pct_full = 12'(({7'd0, used_n} * 12'd100) / 12'(scba_pkg::SmallBlocks));
    unique case (cls_q)
      2'd0: pct_full = 12'(({7'd0, used_n} * 12'd100) / 12'(scba_pkg::SmallBlocks));
      2'd1: pct_full = 12'(({7'd0, used_n} * 12'd100) / 12'(scba_pkg::MediumBlocks));
      2'd2: pct_full = 12'(({7'd0, used_n} * 12'd100) / 12'(scba_pkg::LargeBlocks));
      default: pct_full = 12'(({7'd0, used_n} * 12'd100) / 12'(scba_pkg::XlBlocks));
    endcase
    pct = pct_full[6:0];
  end

  // link memory: one write per cycle, sweep rebuilds each class chain
  logic [BW-1:0] clr_addr;
  logic [scba_pkg::LinkW-1:0] clr_link;
  always_comb begin
    clr_addr = clr_q[BW-1:0];
    clr_link = scba_pkg::LinkW'(clr_q) + 9'd1;
    for (int c = 1; c < 4; c++) begin
      if (clr_addr >= scba_pkg::class_base(2'(c))) begin
        clr_link = scba_pkg::LinkW'(clr_addr - scba_pkg::class_base(2'(c))) + 9'd1;
      end
    end
  end

  logic init_q;
  assign sts_o.init_done = init_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step || !init_q) begin
      link_mem[clr_addr] <= clr_link;
    end else if (cmd_i.exec && f_ok) begin
      link_mem[blk] <= head_q[cls_q];
    end
  end

  // busy table: cleared by the same sweep, set on alloc, cleared on free
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step || !init_q) begin
      busy_mem[clr_addr] <= 1'b0;
    end else if (cmd_i.exec && (a_ok || f_ok)) begin
      busy_mem[blk] <= a_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      init_q  <= 1'b0;
      head_q  <= '0;
      used_q  <= '0;
      peak_q  <= '0;
      alloc_q <= '0;
      rel_q   <= '0;
      fail_q  <= '0;
      seq_q   <= '0;
    end else begin
      if (!init_q) begin
        if (clr_q == (BW+1)'(N - 1)) begin
          init_q <= 1'b1;
          clr_q  <= '0;
        end else begin
          clr_q <= clr_q + 1'b1;
        end
      end else if (cmd_i.clr_start) begin
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.exec) begin
        if (reinit) begin
          head_q  <= '0;
          used_q  <= '0;
          peak_q  <= '0;
          alloc_q <= '0;
          rel_q   <= '0;
          fail_q  <= '0;
          seq_q   <= '0;
        end else begin
          used_q[cls_q]  <= used_n;
          peak_q[cls_q]  <= peak_n;
          alloc_q[cls_q] <= alloc_n;
          rel_q[cls_q]   <= rel_n;
          fail_q[cls_q]  <= fail_n;
          if (a_ok) begin
            head_q[cls_q] <= link_rd_q;
            seq_q         <= seq_q + 16'd1;
          end else if (f_ok) begin
            head_q[cls_q] <= {5'd0, req_q.target_index};
          end
        end
      end
    end
  end

  always_comb begin
    rsp_d = '0;
    rsp_d.status = st;
    if (!no_class) begin
      rsp_d.granted_class = cls_q;
      rsp_d.used_blocks   = used_n;
      rsp_d.peak_blocks   = peak_n;
      rsp_d.alloc_count   = alloc_n;
      rsp_d.free_count    = rel_n;
      rsp_d.fail_count    = fail_n;
      rsp_d.usage_percent = pct;
      if (a_ok) begin
        rsp_d.granted_index = head_q[cls_q][3:0];
        rsp_d.seq_number    = seq_q;
      end
      if (req_q.req_type == scba_pkg::REQ_FREE) begin
        rsp_d.granted_index = req_q.target_index;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end
  assign rsp_o = rsp_q;

  a_single_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(a_ok && f_ok))
    else $error("alloc and free decoded together");
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && a_ok && init_q) |=> (seq_q == $past(seq_q) + 16'd1))
    else $error("sequence number not advanced");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q[0] <= 5'd16) && (used_q[1] <= 5'd16))
    else $error("used count past class size");

endmodule

// ===== rtl/size_class_block_allocator.sv =====
// A transaction is captured at acceptance, executed in the next cycle and its
// result presented in the cycle after that; the next item is accepted in the
// cycle its result is taken, and a stalled result holds off the next input. A
// reinit with the pool enabled adds a sweep over the link and busy tables; after
// reset the same sweep runs first and input is held off until it ends.
// top level: config registers and channel wiring; depends on scba_pkg,
// scba_ctrl and scba_dp
module size_class_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_type[1:0], req_size[17:2], alloc_mode[19:18], target_class[21:20],
  // target_index[25:22], zero fill to 32
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], granted_class[4:3], granted_index[8:5], seq_number[24:9],
  // used_blocks[29:25], peak_blocks[34:30], alloc_count[66:35],
  // free_count[98:67], fail_count[130:99], usage_percent[137:131], zero fill
  output logic [143:0] m_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic             en_q;
  logic [3:0][15:0] lim_q;
  scba_pkg::cmd_t   cmd;
  scba_pkg::sts_t   sts;
  scba_pkg::req_t   req;
  scba_pkg::rsp_t   rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      lim_q <= {16'd4096, 16'd512, 16'd128, 16'd32};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        scba_pkg::REG_POOL_ENABLE:  en_q     <= cfg_data_i[0];
        scba_pkg::REG_SMALL_LIMIT:  lim_q[0] <= cfg_data_i;
        scba_pkg::REG_MEDIUM_LIMIT: lim_q[1] <= cfg_data_i;
        scba_pkg::REG_LARGE_LIMIT:  lim_q[2] <= cfg_data_i;
        scba_pkg::REG_XL_LIMIT:     lim_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign req.req_type     = s_tdata[1:0];
  assign req.req_size     = s_tdata[17:2];
  assign req.alloc_mode   = s_tdata[19:18];
  assign req.target_class = s_tdata[21:20];
  assign req.target_index = s_tdata[25:22];

  scba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  scba_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .sts_o(sts), .req_i(req),
    .pool_enable_i(en_q), .limits_i(lim_q), .rsp_o(rsp)
  );

  assign m_tdata = {6'd0, rsp.usage_percent, rsp.fail_count, rsp.free_count,
                    rsp.alloc_count, rsp.peak_blocks, rsp.used_blocks,
                    rsp.seq_number, rsp.granted_index, rsp.granted_class, rsp.status};

endmodule
